>>> hdl/uwv_pkg.sv
// shared constants, register codes and types of the undecimated wavelet split
package uwv_pkg;

  localparam int DEFAULT_MAX_WIDTH   = 4096;
  localparam int DEFAULT_SAMPLE_BITS = 24;
  localparam int MAX_HEIGHT          = 4096;
  localparam int TAP_COUNT           = 4;
  localparam int TAP_BITS            = 16;
  localparam int HTAP_BITS           = TAP_BITS + 1;
  localparam int FRAC_BITS           = 14;
  localparam int COEFF_BITS          = 25;
  localparam int POS_BITS            = 13;
  localparam int ROW_BITS            = 12;
  localparam int CFG_IDX_BITS        = 3;
  localparam int CFG_DATA_BITS       = 16;

  localparam logic signed [COEFF_BITS-1:0] COEFF_MAX = 25'sh0FFFFFF;
  localparam logic signed [COEFF_BITS-1:0] COEFF_MIN = -25'sh1000000;

  localparam logic signed [TAP_BITS-1:0] TAP0_RESET = -16'sd2120;
  localparam logic signed [TAP_BITS-1:0] TAP1_RESET = 16'sd3672;
  localparam logic signed [TAP_BITS-1:0] TAP2_RESET = 16'sd13705;
  localparam logic signed [TAP_BITS-1:0] TAP3_RESET = 16'sd7913;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DIRECTION    = 3'd0,
    CFG_IMAGE_WIDTH  = 3'd1,
    CFG_IMAGE_HEIGHT = 3'd2,
    CFG_LOW_TAP_0    = 3'd3,
    CFG_LOW_TAP_1    = 3'd4,
    CFG_LOW_TAP_2    = 3'd5,
    CFG_LOW_TAP_3    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_BITS-1:0] col;
    logic [POS_BITS-1:0] row;
    logic                run_last;
    logic                frame_last;
  } res_tag_t;

endpackage

>>> hdl/uwv_ram.sv
// generic single-port-write, single-port-read ram with registered read
module uwv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/uwv_mac.sv
// two-stage tap multiply and sum with floor shift and saturation, output register
module uwv_mac #(
  parameter int SAMPLE_BITS = uwv_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  logic                                      in_valid,
  input  logic signed [SAMPLE_BITS-1:0]             operand [uwv_pkg::TAP_COUNT],
  input  logic signed [uwv_pkg::TAP_BITS-1:0]       low_tap [uwv_pkg::TAP_COUNT],
  input  logic signed [uwv_pkg::HTAP_BITS-1:0]      high_tap [uwv_pkg::TAP_COUNT],
  input  uwv_pkg::res_tag_t                         in_tag,
  output logic                                      out_valid,
  output logic signed [uwv_pkg::COEFF_BITS-1:0]     low_coeff,
  output logic signed [uwv_pkg::COEFF_BITS-1:0]     high_coeff,
  output uwv_pkg::res_tag_t                         out_tag
);
  import uwv_pkg::*;

  localparam int PRODW = SAMPLE_BITS + HTAP_BITS;
  localparam int ACCW  = PRODW + 2;

  logic                    c_valid;
  logic signed [PRODW-1:0] lo_prod [TAP_COUNT];
  logic signed [PRODW-1:0] hi_prod [TAP_COUNT];
  res_tag_t                c_tag;

  logic signed [ACCW-1:0]       lo_sum, hi_sum, lo_sh, hi_sh;
  logic signed [COEFF_BITS-1:0] lo_sat, hi_sat;

  function automatic logic signed [COEFF_BITS-1:0] saturate(input logic signed [ACCW-1:0] v);
    logic signed [COEFF_BITS-1:0] r;
    if (v > ACCW'(COEFF_MAX)) r = COEFF_MAX;
    else if (v < ACCW'(COEFF_MIN)) r = COEFF_MIN;
    else r = v[COEFF_BITS-1:0];
    return r;
  endfunction

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_tag <= in_tag;
      for (int w = 0; w < TAP_COUNT; w++) begin
        lo_prod[w] <= PRODW'(operand[w]) * PRODW'(low_tap[w]);
        hi_prod[w] <= PRODW'(operand[w]) * PRODW'(high_tap[w]);
      end
    end
  end

  // sum, floor shift, saturate
  always_comb begin
    lo_sum = '0;
    hi_sum = '0;
    for (int w = 0; w < TAP_COUNT; w++) begin
      lo_sum = lo_sum + ACCW'(lo_prod[w]);
      hi_sum = hi_sum + ACCW'(hi_prod[w]);
    end
    lo_sh  = lo_sum >>> FRAC_BITS;
    hi_sh  = hi_sum >>> FRAC_BITS;
    lo_sat = saturate(lo_sh);
    hi_sat = saturate(hi_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      low_coeff  <= lo_sat;
      high_coeff <= hi_sat;
      out_tag    <= c_tag;
    end
  end

endmodule

>>> hdl/undecimated_wavelet_split_1d_core.sv
// Undecimated 4-tap wavelet split along rows or columns with symmetric edge mirroring.
// Samples enter in raster order, one beat per clock. The three previous rows live in one
// ram of MAX_WIDTH words, each word holding three samples (one lane per row slot); the ram
// is read at the column of an accepted sample and its word is written back the next clock
// with the new sample in the current slot. An input beat yields 0, 1, 3 or 4 result beats,
// one per clock unless the output stalls; the issue stage holds a sample until its last
// result is issued, so input is taken every clock except in the 3- or 4-result bursts at
// the start and end of each line along the filtered axis and while the output stalls.
module undecimated_wavelet_split_1d_core #(
  parameter int MAX_WIDTH   = uwv_pkg::DEFAULT_MAX_WIDTH,
  parameter int SAMPLE_BITS = uwv_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // config write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [uwv_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [uwv_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // sample
  // output stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [79:0]                          m_tdata,   // low_coeff, high_coeff, out_col, out_row
  output logic                                 m_tlast,   // run_last
  output logic                                 m_tuser    // frame_last
);
  import uwv_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = (CW > ROW_BITS) ? CW : ROW_BITS;
  localparam int PW = EW + 1;
  localparam int LW = 16;
  localparam int MW = 20;

  // config registers
  logic                       direction;
  logic [POS_BITS-1:0]        image_width;
  logic [POS_BITS-1:0]        image_height;
  logic signed [TAP_BITS-1:0] low_tap [TAP_COUNT];
  logic signed [HTAP_BITS-1:0] high_tap [TAP_COUNT];

  // frame position
  logic [CW-1:0]       col_count;
  logic [ROW_BITS-1:0] row_count;
  logic [1:0]          slot;
  logic signed [SAMPLE_BITS-1:0] hist [3];

  // issue stage
  logic                          b_valid, b_first, b_last, b_frame_end;
  logic [1:0]                    b_idx;
  logic [2:0]                    b_n;
  logic [PW-1:0]                 b_first_pos;
  logic [EW-1:0]                 b_e;
  logic [CW-1:0]                 b_c;
  logic [ROW_BITS-1:0]           b_r;
  logic [1:0]                    b_slot;
  logic signed [SAMPLE_BITS-1:0] b_s;
  logic signed [SAMPLE_BITS-1:0] b_hist [3];

  logic [LW-1:0] w_eff, h_eff;
  logic          row_end, frame_end, axis_last, accept, en, emit, idx_last, b_done;
  logic [EW-1:0] e_a;
  logic [PW-1:0] first_a;
  logic [2:0]    n_a;

  logic [3*SAMPLE_BITS-1:0]      rdata, wdata;
  logic signed [SAMPLE_BITS-1:0] win [TAP_COUNT];
  logic signed [SAMPLE_BITS-1:0] operand [TAP_COUNT];
  logic [PW-1:0]                 pos;
  logic [1:0]                    lane [3];
  logic [2:0]                    lsum [3];
  res_tag_t                      tag, out_tag;
  logic                          d_valid;
  logic signed [COEFF_BITS-1:0]  low_coeff, high_coeff;
  logic signed [SAMPLE_BITS-1:0] s_in;

  function automatic logic [1:0] win_index(input logic [PW-1:0] p_in, input logic [1:0] w,
                                           input logic [EW-1:0] e_in, input logic last);
    logic signed [MW-1:0] p, e, q;
    logic [1:0] k;
    p = MW'(p_in) - MW'(w);
    e = MW'(e_in);
    if (p < 0) p = -p - 1;
    if (last && p > e) p = 2 * e + 1 - p;
    q = p - e + 3;
    if (q < 0) k = 2'd0;
    else if (q > 3) k = 2'd3;
    else k = q[1:0];
    return k;
  endfunction

  assign cfg_ready = 1'b1;
  assign s_in      = s_tdata[SAMPLE_BITS-1:0];

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      direction    <= 1'b0;
      image_width  <= POS_BITS'(4096);
      image_height <= POS_BITS'(4096);
      low_tap[0]   <= TAP0_RESET;
      low_tap[1]   <= TAP1_RESET;
      low_tap[2]   <= TAP2_RESET;
      low_tap[3]   <= TAP3_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index)) inside
        CFG_DIRECTION:    direction    <= cfg_data[0];
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[POS_BITS-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[POS_BITS-1:0];
        CFG_LOW_TAP_0, CFG_LOW_TAP_1, CFG_LOW_TAP_2, CFG_LOW_TAP_3: begin
          low_tap[2'(cfg_index - CFG_LOW_TAP_0)] <= cfg_data;
        end
        default: ;
      endcase
    end
  end

  // high taps by quadrature mirror
  always_comb begin
    high_tap[0] = -HTAP_BITS'(low_tap[3]);
    high_tap[1] = HTAP_BITS'(low_tap[2]);
    high_tap[2] = -HTAP_BITS'(low_tap[1]);
    high_tap[3] = HTAP_BITS'(low_tap[0]);
  end

  // clamped sizes and emission plan of the incoming beat
  always_comb begin
    w_eff = LW'(image_width);
    if (w_eff < LW'(4)) w_eff = LW'(4);
    else if (w_eff > LW'(MAX_WIDTH)) w_eff = LW'(MAX_WIDTH);
    h_eff = LW'(image_height);
    if (h_eff < LW'(4)) h_eff = LW'(4);
    else if (h_eff > LW'(MAX_HEIGHT)) h_eff = LW'(MAX_HEIGHT);
    row_end   = LW'(col_count) >= w_eff - LW'(1);
    axis_last = direction ? (LW'(row_count) >= h_eff - LW'(1)) : row_end;
    frame_end = row_end && (LW'(row_count) >= h_eff - LW'(1));
    e_a       = direction ? EW'(row_count) : EW'(col_count);
    if (axis_last && e_a >= EW'(3)) begin
      first_a = PW'(e_a);
      n_a     = 3'd4;
    end else if (e_a == EW'(2)) begin
      first_a = '0;
      n_a     = 3'd3;
    end else if (e_a > EW'(2)) begin
      first_a = PW'(e_a);
      n_a     = 3'd1;
    end else begin
      first_a = '0;
      n_a     = 3'd0;
    end
  end

  assign en       = !d_valid || m_tready;
  assign idx_last = {1'b0, b_idx} == b_n - 3'd1;
  assign emit     = b_valid && (b_n != 3'd0) && en;
  assign b_done   = b_valid && ((b_n == 3'd0) || (en && idx_last));
  assign s_tready = !b_valid || b_done;
  assign accept   = s_tvalid && s_tready;

  // frame counters and sample history
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      slot      <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col_count <= '0;
        row_count <= '0;
        slot      <= '0;
      end else if (row_end) begin
        col_count <= '0;
        row_count <= row_count + 1'b1;
        slot      <= (slot == 2'd2) ? 2'd0 : slot + 2'd1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist[0] <= hist[1];
      hist[1] <= hist[2];
      hist[2] <= s_in;
    end
  end

  // issue stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_first <= 1'b0;
      b_idx   <= '0;
    end else begin
      b_first <= accept;
      if (accept) begin
        b_valid <= 1'b1;
        b_idx   <= '0;
      end else if (b_done) begin
        b_valid <= 1'b0;
      end else if (emit) begin
        b_idx <= b_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_n         <= n_a;
      b_first_pos <= first_a;
      b_e         <= e_a;
      b_last      <= axis_last;
      b_frame_end <= frame_end;
      b_c         <= col_count;
      b_r         <= row_count;
      b_slot      <= slot;
      b_s         <= s_in;
      b_hist      <= hist;
    end
  end

  // row history: one word per column, one lane per row slot
  uwv_ram #(
    .WIDTH (3 * SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (b_valid && b_first),
    .waddr (b_c),
    .wdata (wdata),
    .re    (accept),
    .raddr (col_count),
    .rdata (rdata)
  );

  always_comb begin
    wdata = rdata;
    wdata[b_slot*SAMPLE_BITS +: SAMPLE_BITS] = b_s;
  end

  // window and per-result operand selection
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lsum[j] = {1'b0, b_slot} + 3'(j);
      lane[j] = (lsum[j] >= 3'd3) ? 2'(lsum[j] - 3'd3) : lsum[j][1:0];
      win[j]  = direction ? rdata[lane[j]*SAMPLE_BITS +: SAMPLE_BITS] : b_hist[j];
    end
    win[3] = b_s;
    pos    = b_first_pos + PW'(b_idx);
    for (int w = 0; w < TAP_COUNT; w++) begin
      operand[w] = win[win_index(pos, 2'(w), b_e, b_last)];
    end
    tag.col        = direction ? POS_BITS'(b_c) : POS_BITS'(pos);
    tag.row        = direction ? POS_BITS'(pos) : POS_BITS'(b_r);
    tag.run_last   = idx_last;
    tag.frame_last = idx_last && b_frame_end;
  end

  uwv_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (emit),
    .operand    (operand),
    .low_tap    (low_tap),
    .high_tap   (high_tap),
    .in_tag     (tag),
    .out_valid  (d_valid),
    .low_coeff  (low_coeff),
    .high_coeff (high_coeff),
    .out_tag    (out_tag)
  );

  assign m_tvalid = d_valid;
  assign m_tdata  = {4'b0, out_tag.row, out_tag.col, high_coeff, low_coeff};
  assign m_tlast  = out_tag.run_last;
  assign m_tuser  = out_tag.frame_last;

endmodule

>>> bench/tb.sv
// testbench for the undecimated wavelet split core: predicts every result beat and checks it
`timescale 1ns / 100ps

module tb;
  import uwv_pkg::*;

  typedef struct {
    logic [COEFF_BITS-1:0] low;
    logic [COEFF_BITS-1:0] high;
    logic [POS_BITS-1:0]   col;
    logic [POS_BITS-1:0]   row;
    logic                  run_last;
    logic                  frame_last;
  } coeff_beat_t;

  class wavelet_scoreboard;
    bit                 dir = 0;
    int unsigned        width_reg = 4096;
    int unsigned        height_reg = 4096;
    longint             taps[TAP_COUNT] = '{-2120, 3672, 13705, 7913};
    longint             line_store[3][DEFAULT_MAX_WIDTH];
    longint             recent[3] = '{0, 0, 0};
    int unsigned        col_cnt = 0;
    int unsigned        row_cnt = 0;
    coeff_beat_t        pending[$];
    int                 errors = 0;
    int                 beats_seen = 0;

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] v);
      case (idx)
        CFG_DIRECTION:    dir = v[0];
        CFG_IMAGE_WIDTH:  width_reg = v[POS_BITS-1:0];
        CFG_IMAGE_HEIGHT: height_reg = v[POS_BITS-1:0];
        CFG_LOW_TAP_0:    taps[0] = $signed(v);
        CFG_LOW_TAP_1:    taps[1] = $signed(v);
        CFG_LOW_TAP_2:    taps[2] = $signed(v);
        CFG_LOW_TAP_3:    taps[3] = $signed(v);
        default: ;
      endcase
    endfunction

    function logic [COEFF_BITS-1:0] mirror_fir(longint win[4], longint t[4], int pos, int e,
                                               bit last);
      longint acc;
      longint p;
      longint k;
      acc = 0;
      for (int w = 0; w < TAP_COUNT; w++) begin
        p = pos - w;
        if (p < 0) p = -p - 1;
        if (last && p > e) p = 2 * e + 1 - p;
        k = p - e + 3;
        if (k < 0) k = 0;
        if (k > 3) k = 3;
        acc += t[w] * win[k];
      end
      acc = acc >>> FRAC_BITS;
      if (acc > 16777215) acc = 16777215;
      if (acc < -16777216) acc = -16777216;
      return acc[COEFF_BITS-1:0];
    endfunction

    function void note_sample(logic [DEFAULT_SAMPLE_BITS-1:0] raw);
      int unsigned w, h, c, r, e, first, n;
      bit row_end, frame_end, last;
      longint s;
      longint win[4];
      longint hi[4];
      coeff_beat_t b;
      w = width_reg; h = height_reg; c = col_cnt; r = row_cnt;
      s = $signed(raw);
      if (w < 4) w = 4;
      if (w > DEFAULT_MAX_WIDTH) w = DEFAULT_MAX_WIDTH;
      if (h < 4) h = 4;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      row_end = c >= w - 1;
      frame_end = row_end && r >= h - 1;
      if (c >= DEFAULT_MAX_WIDTH) c = DEFAULT_MAX_WIDTH - 1;
      if (!dir) begin
        for (int j = 0; j < 3; j++) win[j] = recent[j];
        e = c;
        last = row_end;
      end else begin
        for (int j = 0; j < 3; j++) win[j] = line_store[(r + j) % 3][c];
        e = r;
        last = r >= h - 1;
      end
      win[3] = s;
      hi = '{-taps[3], taps[2], -taps[1], taps[0]};
      if (last && e >= 3) begin
        first = e; n = 4;
      end else if (e == 2) begin
        first = 0; n = 3;
      end else if (e > 2) begin
        first = e; n = 1;
      end else begin
        first = 0; n = 0;
      end
      for (int i = 0; i < n; i++) begin
        b.low = mirror_fir(win, taps, first + i, e, last);
        b.high = mirror_fir(win, hi, first + i, e, last);
        b.col = POS_BITS'(dir ? c : first + i);
        b.row = POS_BITS'(dir ? first + i : r);
        b.run_last = (i + 1 == n);
        b.frame_last = (i + 1 == n) && frame_end;
        pending.push_back(b);
      end
      recent[0] = recent[1];
      recent[1] = recent[2];
      recent[2] = s;
      line_store[r % 3][c] = s;
      if (frame_end) begin
        col_cnt = 0; row_cnt = 0;
      end else if (row_end) begin
        col_cnt = 0; row_cnt = r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void check(logic [79:0] d, logic tl, logic tu);
      coeff_beat_t x;
      beats_seen++;
      if (pending.size() == 0) begin
        report($sformatf("result beat with nothing pending, tdata %h", d));
        return;
      end
      x = pending.pop_front();
      if (d[24:0] !== x.low)
        report($sformatf("low_coeff %h, wanted %h", d[24:0], x.low));
      if (d[49:25] !== x.high)
        report($sformatf("high_coeff %h, wanted %h", d[49:25], x.high));
      if (d[62:50] !== x.col)
        report($sformatf("out_col %0d, wanted %0d", d[62:50], x.col));
      if (d[75:63] !== x.row)
        report($sformatf("out_row %0d, wanted %0d", d[75:63], x.row));
      if (tl !== x.run_last)
        report($sformatf("run_last %b, wanted %b", tl, x.run_last));
      if (tu !== x.frame_last)
        report($sformatf("frame_last %b, wanted %b", tu, x.frame_last));
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [79:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  wavelet_scoreboard sb = new();
  int src_idle = 29;
  int sink_idle = 54;
  int sent = 0;
  int frames = 0;

  undecimated_wavelet_split_1d_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check(m_tdata, m_tlast, m_tuser);
    m_tready <= ($urandom_range(99) >= sink_idle);
  end

  task write_cfg(cfg_reg_t idx, logic [15:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
  endtask

  task set_frame(bit d, int w, int h, logic [15:0] t0, logic [15:0] t1, logic [15:0] t2,
                 logic [15:0] t3);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_cfg(CFG_DIRECTION, 16'(d));
    write_cfg(CFG_IMAGE_WIDTH, 16'(w));
    write_cfg(CFG_IMAGE_HEIGHT, 16'(h));
    write_cfg(CFG_LOW_TAP_0, t0);
    write_cfg(CFG_LOW_TAP_1, t1);
    write_cfg(CFG_LOW_TAP_2, t2);
    write_cfg(CFG_LOW_TAP_3, t3);
    cfg_valid <= 0;
  endtask

  task push_sample(logic [23:0] v);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(v);
    sent++;
  endtask

  task send_frame(int w, int h, bit random_data);
    logic [23:0] edge_vals[5];
    edge_vals = '{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF};
    for (int i = 0; i < w * h; i++) begin
      if (!random_data || $urandom_range(9) == 0) push_sample(edge_vals[$urandom_range(4)]);
      else push_sample(24'($urandom));
    end
    s_tvalid <= 0;
    frames++;
  endtask

  initial begin
    int w;
    int h;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // saturating taps on extreme samples, both directions
    set_frame(0, 4, 4, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_frame(4, 4, 0);
    set_frame(1, 4, 4, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_frame(4, 4, 0);
    // undersized frames clamp to four by four
    set_frame(0, 0, 1, -16'sd2120, 16'sd3672, 16'sd13705, 16'sd7913);
    send_frame(4, 4, 1);
    set_frame(1, 2, 0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    send_frame(4, 4, 1);

    while (sent < 410) begin
      if (sent < 137) begin
        src_idle = 29; sink_idle = 54;
      end else if (sent < 274) begin
        src_idle = 54; sink_idle = 29;
      end else begin
        src_idle = 0; sink_idle = 0;
      end
      w = $urandom_range(4, 9);
      h = $urandom_range(4, 7);
      set_frame($urandom_range(1), w, h, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
      send_frame(w, h, 1);
    end

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d samples in %0d frames, %0d result beats checked",
             sent, frames, sb.beats_seen);
    if (sb.errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", sb.pending.size());
    $display("tb: done, errors");
    $finish;
  end

endmodule
